// ===== rtl/mhpq_pkg.sv =====
// Shared types and constants for the min-heap priority queue.
// Used by the top, the sequencer and the testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

  localparam int CAPACITY   = 1024;
  localparam int VALUE_BITS = 32;
  localparam int ADDR_BITS  = $clog2(CAPACITY);
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);
  // Child indexes reach 2 * CAPACITY, one bit past the count width.
  localparam int CHILD_BITS = ADDR_BITS + 2;

  typedef enum logic {
    HF_PUSH = 1'b0,
    HF_POP  = 1'b1
  } heap_func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } heap_status_t;

  typedef struct packed {
    heap_func_t                    func;
    logic signed [VALUE_BITS-1:0]  value;
  } heap_req_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0]  min_value;
    logic                          is_empty;
    logic [COUNT_BITS-1:0]         entry_total;
    heap_status_t                  status;
  } heap_rsp_t;

  // Memory control from the sequencer to the store.
  typedef struct packed {
    logic                          we;
    logic [ADDR_BITS-1:0]          waddr;
    logic signed [VALUE_BITS-1:0]  wdata;
    logic                          re;
    logic [ADDR_BITS-1:0]          ra;
    logic [ADDR_BITS-1:0]          rb;
  } mhpq_mem_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_RD,
    S_POP_LAST,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } mhpq_state_t;

endpackage

`default_nettype wire

// ===== rtl/min_heap_priority_queue.sv =====
// Binary min-heap priority queue of signed 32-bit values with 1024 entries.
// Each accepted beat on req is a push or a pop and yields one rsp beat with the
// minimum after the operation (zero when empty), an empty flag, the entry count
// and a status: push on a full heap or pop on an empty one is ignored and
// flagged. Items are handled one at a time. A push climbs from the new leaf
// towards the root (at most 10 levels) and a pop moves the last entry to the
// root and lets it sink (at most 9 levels); each level is a read of the single
// heap store, whose read data is registered, then a compare and a write.
// Flagged items and a pop that empties the heap do not touch the store. A
// finished result waits in an output register, and the next item is accepted
// while it waits. The store needs no clearing after reset.
// Depends on mhpq_pkg, mhpq_ctrl and mhpq_ram.
`timescale 1ns / 1ps
`default_nettype none

module min_heap_priority_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output      logic                req_stall,
  input  wire mhpq_pkg::heap_req_t req,
  output      logic                rsp_valid,
  input  wire logic                rsp_stall,
  output      mhpq_pkg::heap_rsp_t rsp
);

  import mhpq_pkg::*;

  mhpq_mem_t                    mem;
  logic [VALUE_BITS-1:0]        rd_a_raw, rd_b_raw;
  logic                         res_valid;
  heap_rsp_t                    res;
  logic                         slot_free;

  assign slot_free = !rsp_valid || !rsp_stall;

  mhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_stall (req_stall),
    .slot_free (slot_free),
    .res_valid (res_valid),
    .res       (res),
    .mem       (mem),
    .rd_a      ($signed(rd_a_raw)),
    .rd_b      ($signed(rd_b_raw))
  );

  mhpq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_BITS)
  ) u_store (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .re    (mem.re),
    .ra    (mem.ra),
    .rb    (mem.rb),
    .rd_a  (rd_a_raw),
    .rd_b  (rd_b_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      rsp <= res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mhpq_ram.sv =====
// Generic synchronous RAM: one write port and two read ports, registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] ra,
  input  wire logic [$clog2(DEPTH)-1:0] rb,
  output      logic [WIDTH-1:0]         rd_a,
  output      logic [WIDTH-1:0]         rd_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_a <= mem[ra];
      rd_b <= mem[rb];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mhpq_ctrl.sv =====
// Heap sequencer: push with sift-up, pop with sift-down, over the heap store.
// Depends on mhpq_pkg; drives the store through an mhpq_mem_t bundle.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ctrl (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   req_valid,
  input  wire mhpq_pkg::heap_req_t                    req,
  output      logic                                   req_stall,
  input  wire logic                                   slot_free,
  output      logic                                   res_valid,
  output      mhpq_pkg::heap_rsp_t                    res,
  output      mhpq_pkg::mhpq_mem_t                    mem,
  input  wire logic signed [mhpq_pkg::VALUE_BITS-1:0] rd_a,
  input  wire logic signed [mhpq_pkg::VALUE_BITS-1:0] rd_b
);

  import mhpq_pkg::*;

  mhpq_state_t                  state, state_next;
  logic [COUNT_BITS-1:0]        count, count_next;
  logic [ADDR_BITS-1:0]         pos, pos_next;
  logic signed [VALUE_BITS-1:0] cur, cur_next;
  heap_status_t                 status, status_next;
  logic signed [VALUE_BITS-1:0] root;

  logic [ADDR_BITS-1:0]         parent;
  logic [CHILD_BITS-1:0]        lchild, rchild, count_wide;
  logic                         pick_right;
  logic signed [VALUE_BITS-1:0] pick_val;
  logic [ADDR_BITS-1:0]         pick_idx;

  // The value being placed is carried in cur, and the hole at pos moves
  // instead of swapping, so each level costs one read and one compare.
  assign parent     = (pos - ADDR_BITS'(1)) >> 1;
  assign lchild     = {1'b0, pos, 1'b1};
  assign rchild     = lchild + CHILD_BITS'(1);
  assign count_wide = CHILD_BITS'(count);
  assign pick_right = (rchild < count_wide) && (rd_b < rd_a);
  assign pick_val   = pick_right ? rd_b : rd_a;
  assign pick_idx   = pick_right ? rchild[ADDR_BITS-1:0] : lchild[ADDR_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    pos    <= pos_next;
    cur    <= cur_next;
    status <= status_next;
    if (mem.we && mem.waddr == '0) begin
      root <= mem.wdata;
    end
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    pos_next    = pos;
    cur_next    = cur;
    status_next = status;
    mem         = '0;
    res_valid   = 1'b0;
    req_stall   = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          status_next = ST_OK;
          if (req.func == HF_PUSH) begin
            if (count == COUNT_BITS'(CAPACITY)) begin
              status_next = ST_FULL;
              state_next  = S_DONE;
            end else begin
              cur_next   = req.value;
              pos_next   = count[ADDR_BITS-1:0];
              count_next = count + COUNT_BITS'(1);
              state_next = S_UP_RD;
            end
          end else begin
            if (count == '0) begin
              status_next = ST_EMPTY;
              state_next  = S_DONE;
            end else begin
              count_next = count - COUNT_BITS'(1);
              state_next = (count == COUNT_BITS'(1)) ? S_DONE : S_POP_RD;
            end
          end
        end
      end
      S_UP_RD: begin
        if (pos == '0) begin
          mem.we     = 1'b1;
          mem.waddr  = pos;
          mem.wdata  = cur;
          state_next = S_DONE;
        end else begin
          mem.re     = 1'b1;
          mem.ra     = parent;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem.we    = 1'b1;
        mem.waddr = pos;
        if (cur < rd_a) begin
          mem.wdata  = rd_a;
          pos_next   = parent;
          state_next = S_UP_RD;
        end else begin
          mem.wdata  = cur;
          state_next = S_DONE;
        end
      end
      S_POP_RD: begin
        // The count is already decremented, so it indexes the last entry.
        mem.re     = 1'b1;
        mem.ra     = count[ADDR_BITS-1:0];
        state_next = S_POP_LAST;
      end
      S_POP_LAST: begin
        cur_next   = rd_a;
        pos_next   = '0;
        state_next = S_DN_RD;
      end
      S_DN_RD: begin
        if (lchild >= count_wide) begin
          mem.we     = 1'b1;
          mem.waddr  = pos;
          mem.wdata  = cur;
          state_next = S_DONE;
        end else begin
          mem.re     = 1'b1;
          mem.ra     = lchild[ADDR_BITS-1:0];
          mem.rb     = rchild[ADDR_BITS-1:0];
          state_next = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        mem.we    = 1'b1;
        mem.waddr = pos;
        if (pick_val < cur) begin
          mem.wdata  = pick_val;
          pos_next   = pick_idx;
          state_next = S_DN_RD;
        end else begin
          mem.wdata  = cur;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          res_valid  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.min_value   = (count == '0) ? '0 : root;
    res.is_empty    = (count == '0);
    res.entry_total = count;
    res.status      = status;
  end

  // Reads and writes of the store never share a cycle, which is what keeps
  // the sift loops free of read-after-write hazards.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mem.we && mem.re))
    else $error("store read and write issued in the same cycle");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem.we |-> (COUNT_BITS'(mem.waddr) < count))
    else $error("store write beyond the live entries");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_BITS'(CAPACITY))
    else $error("entry count above capacity");

  a_result_then_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> (state == S_IDLE))
    else $error("sequencer not idle after delivering a result");

  a_count_moves_on_accept: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> $stable(count) || $past(state) == S_IDLE)
    else $error("entry count changed outside of item acceptance");

endmodule

`default_nettype wire

// ===== dv/tb_min_heap_priority_queue.sv =====
// Self-checking testbench for min_heap_priority_queue: directed and random push/pop
// traffic with random idling on both channels, checked against a behavioral heap.
// Depends on mhpq_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_min_heap_priority_queue;
  import mhpq_pkg::*;

  localparam int LATENCY_PAD = 30;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  heap_req_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  heap_rsp_t rsp;

  min_heap_priority_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #1 clk = ~clk;

  // Behavioral heap, kept in step with the accepted request beats.
  logic signed [VALUE_BITS-1:0] shadow_heap [CAPACITY];
  int                           shadow_count = 0;
  heap_rsp_t                    rsp_queue [$];
  heap_req_t                    pending [$];
  int                           err_total = 0;
  int                           rsp_seen = 0;

  task automatic apply_heap_op(input heap_req_t op);
    heap_rsp_t                    want;
    int                           pos;
    int                           par;
    int                           lc;
    int                           pick;
    logic signed [VALUE_BITS-1:0] tmp;
    want.status = ST_OK;
    if (op.func == HF_PUSH) begin
      if (shadow_count >= CAPACITY) begin
        want.status = ST_FULL;
      end else begin
        pos = shadow_count;
        shadow_heap[pos] = op.value;
        shadow_count++;
        while (pos > 0) begin
          par = (pos - 1) / 2;
          if (shadow_heap[pos] < shadow_heap[par]) begin
            tmp = shadow_heap[pos];
            shadow_heap[pos] = shadow_heap[par];
            shadow_heap[par] = tmp;
            pos = par;
          end else begin
            break;
          end
        end
      end
    end else begin
      if (shadow_count == 0) begin
        want.status = ST_EMPTY;
      end else begin
        shadow_count--;
        if (shadow_count > 0) begin
          shadow_heap[0] = shadow_heap[shadow_count];
          pos = 0;
          forever begin
            lc = 2 * pos + 1;
            if (lc >= shadow_count) break;
            pick = lc;
            // On equal children the left one wins.
            if (lc + 1 < shadow_count && shadow_heap[lc + 1] < shadow_heap[lc]) pick = lc + 1;
            if (shadow_heap[pick] < shadow_heap[pos]) begin
              tmp = shadow_heap[pos];
              shadow_heap[pos] = shadow_heap[pick];
              shadow_heap[pick] = tmp;
              pos = pick;
            end else begin
              break;
            end
          end
        end
      end
    end
    want.min_value   = (shadow_count > 0) ? shadow_heap[0] : '0;
    want.is_empty    = (shadow_count == 0);
    want.entry_total = COUNT_BITS'(shadow_count);
    rsp_queue.push_back(want);
  endtask

  function automatic int draw_gap(input bit calm);
    if (calm) return 0;
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
  endfunction

  // Request driver: one beat at a time from the pending queue.
  bit drv_calm = 1'b0;
  int drv_wait = 0;

  always @(posedge clk) begin : req_driver
    int w;
    if (rst) begin
      req_valid <= 1'b0;
      drv_wait  <= $urandom_range(0, 14);
    end else begin
      w = drv_wait;
      if (req_valid && !req_stall) begin
        apply_heap_op(req);
        if ($urandom_range(0, 39) == 0) drv_calm = ~drv_calm;
        w = draw_gap(drv_calm);
      end
      if (!req_valid || !req_stall) begin
        if (w > 0) begin
          req_valid <= 1'b0;
          drv_wait  <= w - 1;
        end else if (pending.size() > 0) begin
          req       <= pending.pop_front();
          req_valid <= 1'b1;
          drv_wait  <= 0;
        end else begin
          req_valid <= 1'b0;
          drv_wait  <= 0;
        end
      end
    end
  end

  // Response monitor: random stall, field-by-field compare against the oldest expectation.
  bit mon_calm = 1'b0;
  int mon_wait = 0;

  always @(posedge clk) begin : rsp_monitor
    int        w;
    heap_rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
      mon_wait  <= 0;
    end else begin
      w = mon_wait;
      if (rsp_valid && !rsp_stall) begin
        rsp_seen++;
        if (rsp_queue.size() == 0) begin
          $display("%0t: unexpected response beat %p", $time, rsp);
          err_total++;
        end else begin
          want = rsp_queue.pop_front();
          if (rsp.min_value !== want.min_value) begin
            $display("%0t: min_value expected %0d actual %0d", $time, want.min_value,
                     rsp.min_value);
            err_total++;
          end
          if (rsp.is_empty !== want.is_empty) begin
            $display("%0t: is_empty expected %0b actual %0b", $time, want.is_empty,
                     rsp.is_empty);
            err_total++;
          end
          if (rsp.entry_total !== want.entry_total) begin
            $display("%0t: entry_total expected %0d actual %0d", $time, want.entry_total,
                     rsp.entry_total);
            err_total++;
          end
          if (rsp.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, rsp.status);
            err_total++;
          end
        end
        if ($urandom_range(0, 39) == 0) mon_calm = ~mon_calm;
        w = draw_gap(mon_calm);
      end
      if (w > 0) begin
        rsp_stall <= 1'b1;
        mon_wait  <= w - 1;
      end else begin
        rsp_stall <= 1'b0;
        mon_wait  <= 0;
      end
    end
  end

  // Occupancy as seen by the stimulus, used to steer the fill phase.
  int plan_count = 0;

  function automatic void add_item(input heap_func_t f, input logic signed [VALUE_BITS-1:0] v);
    heap_req_t it;
    it.func  = f;
    it.value = v;
    pending.push_back(it);
    if (f == HF_PUSH && plan_count < CAPACITY) plan_count++;
    if (f == HF_POP && plan_count > 0) plan_count--;
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 50) return $urandom();
    // A narrow range produces many equal keys.
    if (kind < 75) return $urandom_range(0, 16) - 8;
    if (kind < 85) begin
      case ($urandom_range(0, 3))
        0: return {1'b1, {(VALUE_BITS-1){1'b0}}};
        1: return {1'b0, {(VALUE_BITS-1){1'b1}}};
        2: return '0;
        default: return '1;
      endcase
    end
    return ($urandom() & 32'hFFFF_FF00) | $urandom_range(0, 3);
  endfunction

  initial begin : stimulus
    int push_pct;
    int item_total;
    // Pops on an empty heap are ignored.
    add_item(HF_POP, '0);
    add_item(HF_POP, '1);
    add_item(HF_PUSH, '0);
    add_item(HF_PUSH, {1'b0, {(VALUE_BITS-1){1'b1}}});
    add_item(HF_PUSH, {1'b1, {(VALUE_BITS-1){1'b0}}});
    add_item(HF_PUSH, '1);
    add_item(HF_PUSH, 1);
    add_item(HF_PUSH, 5);
    add_item(HF_PUSH, 5);
    add_item(HF_PUSH, 5);
    add_item(HF_PUSH, '1);
    add_item(HF_PUSH, 32'h5555_5555);
    add_item(HF_PUSH, 32'hAAAA_AAAA);
    repeat (6) add_item(HF_POP, $urandom());
    add_item(HF_PUSH, 5);
    repeat (6) add_item(HF_POP, $urandom());

    for (int seg = 0; seg < 4; seg++) begin
      case ($urandom_range(0, 3))
        0: push_pct = 30;
        1: push_pct = 50;
        2: push_pct = 70;
        default: push_pct = 85;
      endcase
      repeat (50) begin
        if ($urandom_range(0, 99) < push_pct) add_item(HF_PUSH, pick_value());
        else add_item(HF_POP, $urandom());
      end
    end

    // Fill to capacity, then hit the full case, including right after a pop.
    while (plan_count < CAPACITY) add_item(HF_PUSH, pick_value());
    repeat (3) add_item(HF_PUSH, pick_value());
    add_item(HF_POP, $urandom());
    add_item(HF_PUSH, pick_value());
    add_item(HF_PUSH, pick_value());
    // Pops from a full heap walk the deepest sift-down paths.
    repeat (40) add_item(HF_POP, $urandom());
    item_total = pending.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (rsp_seen < item_total) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
    if (err_total == 0 && rsp_queue.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("%0t: timeout with %0d beats outstanding", $time, rsp_queue.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
